>>> hw/rtl/ilft_pkg.sv
// Package for the line field tagger: word types, region and event codes,
// phase encoding and character constants. No dependencies.
package ilft_pkg;

  // Longest keyword that the event decoder knows
  localparam int KW_CHARS = 7;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_HASH  = 8'h23;

  typedef enum logic [2:0] {
    RG_NICK   = 3'd0,
    RG_IDENT  = 3'd1,
    RG_REAL   = 3'd2,
    RG_CMD    = 3'd3,
    RG_TARGET = 3'd4,
    RG_MSG    = 3'd5,
    RG_DROP   = 3'd6
  } region_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_PREFIX,
    PH_COMMAND,
    PH_TARGET,
    PH_MESSAGE
  } phase_t;

  // Dense event numbering in keyword list order
  typedef enum logic [5:0] {
    EV_UNKNOWN, EV_JOIN, EV_PART, EV_KICK, EV_PRIVMSG, EV_NOTICE, EV_PING,
    EV_NICK, EV_MODE, EV_QUIT, EV_TOPIC, EV_INVITE, EV_ERROR,
    EV_R001, EV_R002, EV_R003, EV_R004, EV_R005, EV_R010, EV_R212, EV_R219,
    EV_R242, EV_R251, EV_R252, EV_R253, EV_R254, EV_R255, EV_R256, EV_R257,
    EV_R258, EV_R259, EV_R263, EV_R265, EV_R266, EV_R353, EV_R276, EV_R300,
    EV_R301, EV_R302, EV_R305, EV_R366, EV_R372, EV_R375, EV_R376, EV_R465
  } event_t;

  typedef logic [KW_CHARS-1:0][7:0] kw_chars_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    region_t    region;
    logic       line_end;
    event_t     event_type;
    logic       has_bang;
    logic       has_at;
    logic       sender_from_server;
    logic       target_cleared;
    logic       target_is_sender;
  } out_word_t;

endpackage

>>> hw/rtl/ilft_kw_match.sv
// Command keyword decoder: maps the first command characters and length to
// an event code. Depends on ilft_pkg.
module ilft_kw_match (
  input  ilft_pkg::kw_chars_t chars,
  input  logic [2:0]          len,
  input  logic                has_prefix,
  output ilft_pkg::event_t    kind
);

  logic [23:0] key3;
  logic [31:0] key4;
  logic [39:0] key5;
  logic [47:0] key6;
  logic [55:0] key7;
  ilft_pkg::event_t cand;

  assign key3 = {chars[0], chars[1], chars[2]};
  assign key4 = {key3, chars[3]};
  assign key5 = {key4, chars[4]};
  assign key6 = {key5, chars[5]};
  assign key7 = {key6, chars[6]};

  always_comb begin
    cand = ilft_pkg::EV_UNKNOWN;
    case (len)
      3'd3: begin
        case (key3)
          "001": cand = ilft_pkg::EV_R001;
          "002": cand = ilft_pkg::EV_R002;
          "003": cand = ilft_pkg::EV_R003;
          "004": cand = ilft_pkg::EV_R004;
          "005": cand = ilft_pkg::EV_R005;
          "010": cand = ilft_pkg::EV_R010;
          "212": cand = ilft_pkg::EV_R212;
          "219": cand = ilft_pkg::EV_R219;
          "242": cand = ilft_pkg::EV_R242;
          "221": cand = ilft_pkg::EV_MODE;
          "251": cand = ilft_pkg::EV_R251;
          "252": cand = ilft_pkg::EV_R252;
          "253": cand = ilft_pkg::EV_R253;
          "254": cand = ilft_pkg::EV_R254;
          "255": cand = ilft_pkg::EV_R255;
          "256": cand = ilft_pkg::EV_R256;
          "257": cand = ilft_pkg::EV_R257;
          "258": cand = ilft_pkg::EV_R258;
          "259": cand = ilft_pkg::EV_R259;
          "263": cand = ilft_pkg::EV_R263;
          "265": cand = ilft_pkg::EV_R265;
          "266": cand = ilft_pkg::EV_R266;
          "353": cand = ilft_pkg::EV_R353;
          "276": cand = ilft_pkg::EV_R276;
          "300": cand = ilft_pkg::EV_R300;
          "301": cand = ilft_pkg::EV_R301;
          "302": cand = ilft_pkg::EV_R302;
          "305": cand = ilft_pkg::EV_R305;
          "366": cand = ilft_pkg::EV_R366;
          "372": cand = ilft_pkg::EV_R372;
          "375": cand = ilft_pkg::EV_R375;
          "376": cand = ilft_pkg::EV_R376;
          "465": cand = ilft_pkg::EV_R465;
          default: cand = ilft_pkg::EV_UNKNOWN;
        endcase
      end
      3'd4: begin
        case (key4)
          "JOIN": cand = ilft_pkg::EV_JOIN;
          "PART": cand = ilft_pkg::EV_PART;
          "KICK": cand = ilft_pkg::EV_KICK;
          "PING": cand = ilft_pkg::EV_PING;
          "NICK": cand = ilft_pkg::EV_NICK;
          "MODE": cand = ilft_pkg::EV_MODE;
          "QUIT": cand = ilft_pkg::EV_QUIT;
          default: cand = ilft_pkg::EV_UNKNOWN;
        endcase
      end
      3'd5: begin
        case (key5)
          "TOPIC": cand = ilft_pkg::EV_TOPIC;
          "ERROR": cand = ilft_pkg::EV_ERROR;
          default: cand = ilft_pkg::EV_UNKNOWN;
        endcase
      end
      3'd6: begin
        case (key6)
          "NOTICE": cand = ilft_pkg::EV_NOTICE;
          "INVITE": cand = ilft_pkg::EV_INVITE;
          default:  cand = ilft_pkg::EV_UNKNOWN;
        endcase
      end
      3'd7: begin
        if (key7 == "PRIVMSG") begin
          cand = ilft_pkg::EV_PRIVMSG;
        end
      end
      default: cand = ilft_pkg::EV_UNKNOWN;
    endcase
  end

  // Without a prefix only server-level events are recognized
  always_comb begin
    kind = cand;
    if (!has_prefix && cand != ilft_pkg::EV_PING && cand != ilft_pkg::EV_ERROR) begin
      kind = ilft_pkg::EV_UNKNOWN;
    end
  end

endmodule

>>> hw/rtl/ilft_tagger.sv
// Per-line parse state and per-byte tagging logic for the line field tagger.
// Depends on ilft_pkg and ilft_kw_match.
module ilft_tagger #(
  parameter int CMD_CHARS = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  ilft_pkg::in_word_t  word,
  output ilft_pkg::out_word_t result
);

  localparam int LW = $clog2(CMD_CHARS + 2);
  localparam int IW = $clog2(CMD_CHARS);

  ilft_pkg::phase_t phase, phase_next;
  logic                has_prefix, has_prefix_next;
  logic [7:0]          cmd_buf [CMD_CHARS];
  logic [LW-1:0]       cmd_len, cmd_len_next;
  logic                seen_bang, seen_bang_next;
  logic                seen_at, seen_at_next;
  ilft_pkg::event_t    kind_code, kind_code_next;
  logic                field_first, field_first_next;
  logic                channel_flag, channel_flag_next;

  logic                is_crlf, is_space, is_colon, is_bang, is_at, is_hash;
  logic                push;
  ilft_pkg::kw_chars_t view;
  logic [2:0]          kw_len;
  ilft_pkg::event_t    kind_match;
  ilft_pkg::event_t    ev;
  ilft_pkg::region_t   region;
  logic [7:0]          b;

  assign b        = word.in_byte;
  assign is_crlf  = (b == ilft_pkg::CH_CR) || (b == ilft_pkg::CH_LF);
  assign is_space = (b == ilft_pkg::CH_SPACE);
  assign is_colon = (b == ilft_pkg::CH_COLON);
  assign is_bang  = (b == ilft_pkg::CH_BANG);
  assign is_at    = (b == ilft_pkg::CH_AT);
  assign is_hash  = (b == ilft_pkg::CH_HASH);

  assign push = !is_crlf && !is_space &&
                ((phase == ilft_pkg::PH_START && !is_colon) || phase == ilft_pkg::PH_COMMAND);

  // Command as it stands after this byte, so a match sees the current byte
  always_comb begin
    for (int i = 0; i < ilft_pkg::KW_CHARS; i++) begin
      view[i] = (push && cmd_len == LW'(i)) ? b : cmd_buf[i];
    end
  end

  assign cmd_len_next = (push && cmd_len <= LW'(CMD_CHARS)) ? cmd_len + LW'(1) : cmd_len;
  assign kw_len = (cmd_len_next <= LW'(ilft_pkg::KW_CHARS)) ? cmd_len_next[2:0] : 3'd0;

  ilft_kw_match u_kw_match (
    .chars      (view),
    .len        (kw_len),
    .has_prefix (has_prefix),
    .kind       (kind_match)
  );

  // Next state
  always_comb begin
    phase_next        = phase;
    has_prefix_next   = has_prefix;
    seen_bang_next    = seen_bang;
    seen_at_next      = seen_at;
    kind_code_next    = kind_code;
    field_first_next  = field_first;
    channel_flag_next = channel_flag;
    if (!is_crlf) begin
      unique case (phase)
        ilft_pkg::PH_START: begin
          if (is_colon) begin
            has_prefix_next = 1'b1;
            phase_next      = ilft_pkg::PH_PREFIX;
          end else if (is_space) begin
            kind_code_next   = kind_match;
            phase_next       = ilft_pkg::PH_TARGET;
            field_first_next = 1'b1;
          end else begin
            phase_next = ilft_pkg::PH_COMMAND;
          end
        end
        ilft_pkg::PH_PREFIX: begin
          if (is_space) begin
            phase_next = ilft_pkg::PH_COMMAND;
          end else if (is_bang && !seen_bang) begin
            seen_bang_next = 1'b1;
          end else if (is_at && seen_bang && !seen_at) begin
            seen_at_next = 1'b1;
          end
        end
        ilft_pkg::PH_COMMAND: begin
          if (is_space) begin
            kind_code_next   = kind_match;
            phase_next       = ilft_pkg::PH_TARGET;
            field_first_next = 1'b1;
          end
        end
        ilft_pkg::PH_TARGET: begin
          if (is_space) begin
            phase_next       = ilft_pkg::PH_MESSAGE;
            field_first_next = 1'b1;
          end else begin
            if (field_first && is_hash) begin
              channel_flag_next = 1'b1;
            end
            field_first_next = 1'b0;
          end
        end
        ilft_pkg::PH_MESSAGE: begin
          field_first_next = 1'b0;
        end
        default: phase_next = phase;
      endcase
    end
  end

  // Outputs
  always_comb begin
    region = ilft_pkg::RG_DROP;
    if (!is_crlf) begin
      unique case (phase)
        ilft_pkg::PH_START: begin
          if (!is_colon && !is_space) begin
            region = ilft_pkg::RG_CMD;
          end
        end
        ilft_pkg::PH_PREFIX: begin
          if (is_space || (is_bang && !seen_bang) || (is_at && seen_bang && !seen_at)) begin
            region = ilft_pkg::RG_DROP;
          end else if (seen_at) begin
            region = ilft_pkg::RG_REAL;
          end else if (seen_bang) begin
            region = ilft_pkg::RG_IDENT;
          end else begin
            region = ilft_pkg::RG_NICK;
          end
        end
        ilft_pkg::PH_COMMAND: begin
          if (!is_space) begin
            region = ilft_pkg::RG_CMD;
          end
        end
        ilft_pkg::PH_TARGET: begin
          if (!is_space) begin
            region = ilft_pkg::RG_TARGET;
          end
        end
        ilft_pkg::PH_MESSAGE: begin
          if (!(field_first && is_colon)) begin
            region = ilft_pkg::RG_MSG;
          end
        end
        default: region = ilft_pkg::RG_DROP;
      endcase
    end

    // A command still open at the line end is matched here
    ev = (phase_next == ilft_pkg::PH_COMMAND) ? kind_match : kind_code_next;

    result.out_byte           = b;
    result.region             = region;
    result.line_end           = word.last;
    result.event_type         = ilft_pkg::EV_UNKNOWN;
    result.has_bang           = 1'b0;
    result.has_at             = 1'b0;
    result.sender_from_server = 1'b0;
    result.target_cleared     = 1'b0;
    result.target_is_sender   = 1'b0;
    if (word.last) begin
      result.event_type         = ev;
      result.has_bang           = seen_bang_next;
      result.has_at             = seen_at_next;
      result.sender_from_server = (ev == ilft_pkg::EV_PING);
      result.target_cleared     = (ev == ilft_pkg::EV_ERROR);
      result.target_is_sender   = (ev == ilft_pkg::EV_PRIVMSG) && channel_flag_next;
    end
  end

  // Control state; clear for the next line after the last byte
  always_ff @(posedge clk) begin
    if (rst || (step && word.last)) begin
      phase        <= ilft_pkg::PH_START;
      has_prefix   <= 1'b0;
      cmd_len      <= '0;
      seen_bang    <= 1'b0;
      seen_at      <= 1'b0;
      kind_code    <= ilft_pkg::EV_UNKNOWN;
      field_first  <= 1'b1;
      channel_flag <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      has_prefix   <= has_prefix_next;
      cmd_len      <= cmd_len_next;
      seen_bang    <= seen_bang_next;
      seen_at      <= seen_at_next;
      kind_code    <= kind_code_next;
      field_first  <= field_first_next;
      channel_flag <= channel_flag_next;
    end
  end

  // Command characters; only the first cmd_len entries are ever compared
  always_ff @(posedge clk) begin
    if (step && push && cmd_len < LW'(CMD_CHARS)) begin
      cmd_buf[cmd_len[IW-1:0]] <= b;
    end
  end

endmodule

>>> hw/rtl/irc_line_field_tagger.sv
// Path: an accepted word waits in the input register, is tagged combinationally and is
//   then registered into the result register that drives out_valid and out_data.
// Throughput: one byte per cycle; the parse state advances as the input register
//   hands its word to the result register, so back-to-back bytes never stall while
//   out_ready stays high.
// Reset: synchronous rst empties both registers and returns the parser to line start.
// Depends on ilft_pkg, ilft_tagger and ilft_kw_match.
module irc_line_field_tagger #(
  parameter int CMD_CHARS = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ilft_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ilft_pkg::out_word_t out_data
);

  logic                s1_valid;
  ilft_pkg::in_word_t  s1_data;
  logic                advance;
  ilft_pkg::out_word_t result;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  ilft_tagger #(
    .CMD_CHARS (CMD_CHARS)
  ) u_tagger (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .word   (s1_data),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  a_summary_only_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.line_end |-> out_data.event_type == ilft_pkg::EV_UNKNOWN &&
      !out_data.has_bang && !out_data.has_at && !out_data.target_is_sender)
    else $error("summary fields set before line end");

  a_ping_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.sender_from_server == (out_data.event_type == ilft_pkg::EV_PING))
    else $error("sender_from_server does not follow event type");

  a_channel_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.target_is_sender |-> out_data.event_type == ilft_pkg::EV_PRIVMSG)
    else $error("channel flag on a non-PRIVMSG event");

  a_at_needs_bang: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.has_at |-> out_data.has_bang)
    else $error("has_at without has_bang");

  a_stall_holds_word: assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> s1_valid && $stable(s1_data))
    else $error("input register lost a word while stalled");

endmodule

>>> tb/sv/irc_line_field_tagger_tb.sv
// Self-checking bench for irc_line_field_tagger: drives protocol lines a byte per word,
// predicts each byte's region and the line-end event summary, and checks every result.
// Depends on ilft_pkg and the irc_line_field_tagger RTL.
module irc_line_field_tagger_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ilft_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int BYTE_GOAL  = 1300;

  class tag_tracker;
    out_word_t   pending_tags[$];
    int          errors;
    int          bytes_seen;
    int          lines_seen;
    bit [63:0]   events_hit;

    phase_t      phase;
    bit          has_prefix;
    logic [55:0] cmd_word;
    int unsigned cmd_len;
    bit          seen_bang;
    bit          seen_at;
    event_t      kind;
    bit          first_of_field;
    bit          chan;

    function new();
      errors     = 0;
      bytes_seen = 0;
      lines_seen = 0;
      events_hit = '0;
      clear_line();
    endfunction

    function void clear_line();
      phase          = PH_START;
      has_prefix     = 1'b0;
      cmd_word       = '0;
      cmd_len        = 0;
      seen_bang      = 1'b0;
      seen_at        = 1'b0;
      kind           = EV_UNKNOWN;
      first_of_field = 1'b1;
      chan           = 1'b0;
    endfunction

    // Keep only the first KW_CHARS bytes, right aligned; count one past to flag overlong.
    function void push_cmd(logic [7:0] b);
      if (cmd_len < KW_CHARS) cmd_word = {cmd_word[47:0], b};
      if (cmd_len <= KW_CHARS) cmd_len++;
    endfunction

    function event_t lookup();
      event_t ev;
      ev = EV_UNKNOWN;
      if (cmd_len == 4 && cmd_word[31:0] == "PING") return EV_PING;
      if (cmd_len == 5 && cmd_word[39:0] == "ERROR") return EV_ERROR;
      if (!has_prefix) return EV_UNKNOWN;
      case (cmd_len)
        3: case (cmd_word[23:0])
          "001": ev = EV_R001;  "002": ev = EV_R002;  "003": ev = EV_R003;
          "004": ev = EV_R004;  "005": ev = EV_R005;  "010": ev = EV_R010;
          "212": ev = EV_R212;  "219": ev = EV_R219;  "242": ev = EV_R242;
          "221": ev = EV_MODE;  "251": ev = EV_R251;  "252": ev = EV_R252;
          "253": ev = EV_R253;  "254": ev = EV_R254;  "255": ev = EV_R255;
          "256": ev = EV_R256;  "257": ev = EV_R257;  "258": ev = EV_R258;
          "259": ev = EV_R259;  "263": ev = EV_R263;  "265": ev = EV_R265;
          "266": ev = EV_R266;  "353": ev = EV_R353;  "276": ev = EV_R276;
          "300": ev = EV_R300;  "301": ev = EV_R301;  "302": ev = EV_R302;
          "305": ev = EV_R305;  "366": ev = EV_R366;  "372": ev = EV_R372;
          "375": ev = EV_R375;  "376": ev = EV_R376;  "465": ev = EV_R465;
          default: ev = EV_UNKNOWN;
        endcase
        4: case (cmd_word[31:0])
          "JOIN": ev = EV_JOIN;  "PART": ev = EV_PART;  "KICK": ev = EV_KICK;
          "NICK": ev = EV_NICK;  "MODE": ev = EV_MODE;  "QUIT": ev = EV_QUIT;
          default: ev = EV_UNKNOWN;
        endcase
        5: if (cmd_word[39:0] == "TOPIC") ev = EV_TOPIC;
        6: case (cmd_word[47:0])
          "NOTICE": ev = EV_NOTICE;
          "INVITE": ev = EV_INVITE;
          default:  ev = EV_UNKNOWN;
        endcase
        7: if (cmd_word == "PRIVMSG") ev = EV_PRIVMSG;
        default: ev = EV_UNKNOWN;
      endcase
      return ev;
    endfunction

    function void note_byte(in_word_t w);
      logic [7:0] b;
      region_t    rg;
      out_word_t  tag;
      b  = w.in_byte;
      rg = RG_DROP;
      bytes_seen++;
      if (b != CH_CR && b != CH_LF) begin
        case (phase)
          PH_START: begin
            if (b == CH_COLON) begin
              has_prefix = 1'b1;
              phase      = PH_PREFIX;
            end else if (b == CH_SPACE) begin
              kind           = lookup();
              phase          = PH_TARGET;
              first_of_field = 1'b1;
            end else begin
              push_cmd(b);
              phase = PH_COMMAND;
              rg    = RG_CMD;
            end
          end
          PH_PREFIX: begin
            if (b == CH_SPACE) begin
              phase = PH_COMMAND;
            end else if (b == CH_BANG && !seen_bang) begin
              seen_bang = 1'b1;
            end else if (b == CH_AT && seen_bang && !seen_at) begin
              seen_at = 1'b1;
            end else begin
              rg = seen_at ? RG_REAL : (seen_bang ? RG_IDENT : RG_NICK);
            end
          end
          PH_COMMAND: begin
            if (b == CH_SPACE) begin
              kind           = lookup();
              phase          = PH_TARGET;
              first_of_field = 1'b1;
            end else begin
              push_cmd(b);
              rg = RG_CMD;
            end
          end
          PH_TARGET: begin
            if (b == CH_SPACE) begin
              phase          = PH_MESSAGE;
              first_of_field = 1'b1;
            end else begin
              if (first_of_field && b == CH_HASH) chan = 1'b1;
              first_of_field = 1'b0;
              rg             = RG_TARGET;
            end
          end
          default: begin
            // drop the message's leading colon only
            if (!(first_of_field && b == CH_COLON)) rg = RG_MSG;
            first_of_field = 1'b0;
          end
        endcase
      end

      tag          = '0;
      tag.out_byte = b;
      tag.region   = rg;
      tag.line_end = w.last;
      if (w.last) begin
        if (phase == PH_COMMAND) kind = lookup();
        tag.event_type         = kind;
        tag.has_bang           = seen_bang;
        tag.has_at             = seen_at;
        tag.sender_from_server = (kind == EV_PING);
        tag.target_cleared     = (kind == EV_ERROR);
        tag.target_is_sender   = (kind == EV_PRIVMSG) && chan;
        events_hit[kind]       = 1'b1;
        lines_seen++;
        clear_line();
      end
      pending_tags.push_back(tag);
    endfunction

    function void field_check(string fname, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, got %0d", fname, want, got);
        errors++;
      end
    endfunction

    function void check_tag(out_word_t got);
      out_word_t want;
      if (pending_tags.size() == 0) begin
        $error("result word with no byte pending: %h", got);
        errors++;
        return;
      end
      want = pending_tags.pop_front();
      field_check("out_byte", want.out_byte, got.out_byte);
      field_check("region", want.region, got.region);
      field_check("line_end", want.line_end, got.line_end);
      field_check("event_type", want.event_type, got.event_type);
      field_check("has_bang", want.has_bang, got.has_bang);
      field_check("has_at", want.has_at, got.has_at);
      field_check("sender_from_server", want.sender_from_server, got.sender_from_server);
      field_check("target_cleared", want.target_cleared, got.target_cleared);
      field_check("target_is_sender", want.target_is_sender, got.target_is_sender);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  tag_tracker tags = new();

  logic [7:0] line_buf[$];
  int         burst_left = 0;
  int         stall_mode = 0;
  int         stall_left = 0;
  int         idle_cycles = 0;

  string keywords [45] = '{
    "JOIN", "PART", "KICK", "PRIVMSG", "NOTICE", "PING", "NICK", "MODE", "QUIT",
    "TOPIC", "INVITE", "ERROR", "001", "002", "003", "004", "005", "010", "212",
    "219", "242", "221", "251", "252", "253", "254", "255", "256", "257", "258",
    "259", "263", "265", "266", "353", "276", "300", "301", "302", "305", "366",
    "372", "375", "376", "465"
  };

  irc_line_field_tagger DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) tags.note_byte(in_data);
    if (!rst && out_valid && out_ready) tags.check_tag(out_data);
  end

  // Receiver: switch between always ready, light and heavy stalling
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 150);
    end
    stall_left--;
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function logic [7:0] token_char();
    if ($urandom_range(0, 15) == 0) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(33, 126));
  endfunction

  function void add_text(int n);
    for (int i = 0; i < n; i++) line_buf.push_back(token_char());
  endfunction

  function void add_str(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function void build_line();
    int r;
    int cut;
    line_buf.delete();
    if ($urandom_range(0, 3) != 0) begin
      line_buf.push_back(CH_COLON);
      add_text($urandom_range(0, 4));
      if ($urandom_range(0, 3) != 0) begin
        line_buf.push_back(CH_BANG);
        add_text($urandom_range(0, 3));
        if ($urandom_range(0, 3) != 0) begin
          line_buf.push_back(CH_AT);
          add_text($urandom_range(0, 4));
        end
      end
      line_buf.push_back(CH_SPACE);
    end else if ($urandom_range(0, 9) == 0) begin
      line_buf.push_back(CH_SPACE);
    end
    r = $urandom_range(0, 9);
    if (r < 7) add_str(keywords[$urandom_range(0, 44)]);
    else if (r == 7) begin
      if ($urandom_range(0, 1)) add_str("PING");
      else add_str("ERROR");
    end
    else if (r == 8) add_text($urandom_range(0, 3));
    else add_text($urandom_range(8, 10));
    line_buf.push_back(CH_SPACE);
    if ($urandom_range(0, 1)) line_buf.push_back(CH_HASH);
    add_text($urandom_range(0, 3));
    line_buf.push_back(CH_SPACE);
    if ($urandom_range(0, 3) != 0) line_buf.push_back(CH_COLON);
    repeat ($urandom_range(0, 6))
      line_buf.push_back(($urandom_range(0, 5) == 0) ? CH_SPACE : token_char());
    if ($urandom_range(0, 1)) begin
      line_buf.push_back(CH_CR);
      line_buf.push_back(CH_LF);
    end
    // end the line early now and then
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(0, line_buf.size() - 1);
      line_buf = line_buf[0:cut];
    end
  endfunction

  function void build_noise();
    line_buf.delete();
    repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
  endfunction

  task automatic send_word(in_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_line();
    in_word_t w;
    for (int i = 0; i < line_buf.size(); i++) begin
      w.in_byte = line_buf[i];
      w.last    = (i == line_buf.size() - 1);
      send_word(w);
    end
  endtask

  // Hold the sender until every expected word has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tags.pending_tags.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    line_buf = '{8'hFF, 8'h00};
    send_line();
    line_buf.delete(); add_str(" 0");       send_line();
    line_buf.delete(); add_str(":!@ 465");  send_line();
    line_buf.delete(); add_str("PING\n");   send_line();
    line_buf.delete(); add_str("ERROR");    send_line();
    line_buf.delete(); add_str(":a 221 #"); send_line();
    drain();

    while (tags.bytes_seen < BYTE_GOAL) begin
      if ($urandom_range(0, 6) == 0) build_noise();
      else build_line();
      send_line();
      if ($urandom_range(0, 14) == 0) drain();
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d bytes in %0d lines, bursty sender against a stalling receiver",
             tags.bytes_seen, tags.lines_seen);
    $display("Line-end event codes seen: %0d distinct", $countones(tags.events_hit));
    if (tags.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
